FILE: sv/m2pf_pkg.sv
// Package for the 2x2 matrix power unit: widths, microcode format and program store.
`timescale 1ns / 1ps

package m2pf_pkg;

   localparam int ENTRY_BITS = 64;
   localparam int EXP_BITS   = 8;
   localparam int HALF_BITS  = (ENTRY_BITS + 1) / 2;
   localparam int HIGH_BITS  = ENTRY_BITS - HALF_BITS;
   localparam int PROD_BITS  = 2 * HALF_BITS;
   localparam int PC_BITS    = 4;
   localparam int STEP_BITS  = 3;

   // Sub-steps of one entry product: two terms of three partial products, then a drain.
   localparam logic [STEP_BITS-1:0] STEP_TERM1 = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] STEP_DRAIN = STEP_BITS'(6);

   localparam logic [1:0] PART_LL = 2'd0;
   localparam logic [1:0] PART_LH = 2'd1;
   localparam logic [1:0] PART_HL = 2'd2;

   localparam logic [PC_BITS-1:0] PC_TOP      = PC_BITS'(0);
   localparam logic [PC_BITS-1:0] PC_MUL_ACC  = PC_BITS'(2);
   localparam logic [PC_BITS-1:0] PC_COPY_ACC = PC_BITS'(6);
   localparam logic [PC_BITS-1:0] PC_MUL_BASE = PC_BITS'(7);
   localparam logic [PC_BITS-1:0] PC_COPY_BSE = PC_BITS'(11);
   localparam logic [PC_BITS-1:0] PC_DONE     = PC_BITS'(12);

   typedef logic [3:0][ENTRY_BITS-1:0] mat_type;

   typedef enum logic [2:0] {
      OP_JZ,
      OP_JEVEN,
      OP_MUL,
      OP_COPY_ACC,
      OP_COPY_BASE,
      OP_DONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               x_base;
      logic [1:0]         entry;
      logic [PC_BITS-1:0] target;
   } ctrl_type;

   function automatic ctrl_type mc_word(input op_type op, input logic x_base,
                                        input logic [1:0] entry,
                                        input logic [PC_BITS-1:0] target);
      ctrl_type w;
      w.op     = op;
      w.x_base = x_base;
      w.entry  = entry;
      w.target = target;
      return w;
   endfunction

   // Program: test exponent, optional acc*base, base*base, shift, loop.
   function automatic ctrl_type mc_rom(input logic [PC_BITS-1:0] addr);
      ctrl_type w;
      w = mc_word(OP_DONE, 1'b0, 2'd0, PC_TOP);
      if (addr == PC_TOP) begin
         w = mc_word(OP_JZ, 1'b0, 2'd0, PC_DONE);
      end else if (addr < PC_MUL_ACC) begin
         w = mc_word(OP_JEVEN, 1'b0, 2'd0, PC_MUL_BASE);
      end else if (addr < PC_COPY_ACC) begin
         w = mc_word(OP_MUL, 1'b0, 2'(addr - PC_MUL_ACC), PC_TOP);
      end else if (addr == PC_COPY_ACC) begin
         w = mc_word(OP_COPY_ACC, 1'b0, 2'd0, PC_TOP);
      end else if (addr < PC_COPY_BSE) begin
         w = mc_word(OP_MUL, 1'b1, 2'(addr - PC_MUL_BASE), PC_TOP);
      end else if (addr == PC_COPY_BSE) begin
         w = mc_word(OP_COPY_BASE, 1'b0, 2'd0, PC_TOP);
      end
      return w;
   endfunction

endpackage

FILE: sv/matrix2x2_power_fibonacci.sv
// 2x2 matrix power / Fibonacci unit, microcoded over one shared half-width multiplier.
`timescale 1ns / 1ps

// Takes one request at a time and returns one result. Mode 0 returns A^n; mode 1
// returns [[1,1],[1,0]]^(n-1), with F(n) in fib_value (all zero for n = 0). Arithmetic
// wraps modulo 2^64. A small microcode program scans the exponent from its low bit.
// Each matrix entry product runs on the single 32x32 multiplier as three partial
// products per term over two terms, then one drain step. Every exponent bit squares
// the base; a set bit also multiplies the accumulator by the base first. A finished
// result waits in the output register while the next request is taken.
module matrix2x2_power_fibonacci (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [m2pf_pkg::ENTRY_BITS-1:0] req_a00,
   input  logic [m2pf_pkg::ENTRY_BITS-1:0] req_a01,
   input  logic [m2pf_pkg::ENTRY_BITS-1:0] req_a10,
   input  logic [m2pf_pkg::ENTRY_BITS-1:0] req_a11,
   input  logic [m2pf_pkg::EXP_BITS-1:0]   req_exponent,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [m2pf_pkg::ENTRY_BITS-1:0] rsp_r00,
   output logic [m2pf_pkg::ENTRY_BITS-1:0] rsp_r01,
   output logic [m2pf_pkg::ENTRY_BITS-1:0] rsp_r10,
   output logic [m2pf_pkg::ENTRY_BITS-1:0] rsp_r11,
   output logic [m2pf_pkg::ENTRY_BITS-1:0] rsp_fib_value
);
   import m2pf_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   localparam logic [ENTRY_BITS-1:0] ONE  = ENTRY_BITS'(1);
   localparam logic [ENTRY_BITS-1:0] ZERO = '0;

   state_type                state_ff, state_in;
   logic [PC_BITS-1:0]       pc_ff, pc_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     mul_vld_ff, mul_vld_in;
   logic                     mul_shift_ff, mul_shift_in;
   logic [PROD_BITS-1:0]     mul_ff, mul_in;
   logic [ENTRY_BITS-1:0]    sum_ff, sum_in;
   logic [EXP_BITS-1:0]      n_ff, n_in;
   mat_type                  acc_ff, acc_in;
   mat_type                  base_ff, base_in;
   mat_type                  prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mat_type                  rsp_ff, rsp_in;

   ctrl_type                 ctrl;
   logic                     term;
   logic [1:0]               part;
   mat_type                  x_mat;
   logic [ENTRY_BITS-1:0]    x_op, y_op;
   logic [HALF_BITS-1:0]     opa, opb;
   logic [ENTRY_BITS-1:0]    addend;
   logic [ENTRY_BITS-1:0]    sum_next;

   always_comb begin
      ctrl     = mc_rom(pc_ff);
      term     = (step_ff >= STEP_TERM1);
      part     = term ? 2'(step_ff - STEP_TERM1) : 2'(step_ff);
      x_mat    = ctrl.x_base ? base_ff : acc_ff;
      x_op     = x_mat[{ctrl.entry[1], term}];
      y_op     = base_ff[{term, ctrl.entry[0]}];
      opa      = (part == PART_HL) ? HALF_BITS'(x_op[ENTRY_BITS-1:HALF_BITS])
                                   : x_op[HALF_BITS-1:0];
      opb      = (part == PART_LH) ? HALF_BITS'(y_op[ENTRY_BITS-1:HALF_BITS])
                                   : y_op[HALF_BITS-1:0];
      addend   = mul_shift_ff ? {mul_ff[HIGH_BITS-1:0], {HALF_BITS{1'b0}}}
                              : mul_ff[ENTRY_BITS-1:0];
      sum_next = sum_ff + (mul_vld_ff ? addend : ZERO);
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      step_in      = step_ff;
      mul_vld_in   = 1'b0;
      mul_shift_in = mul_shift_ff;
      mul_in       = mul_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               pc_in    = PC_TOP;
               step_in  = '0;
               sum_in   = ZERO;
               if (!req_type) begin
                  acc_in  = {ONE, ZERO, ZERO, ONE};
                  base_in = {req_a11, req_a10, req_a01, req_a00};
                  n_in    = req_exponent;
               end else if (req_exponent == '0) begin
                  acc_in  = {ZERO, ZERO, ZERO, ZERO};
                  base_in = {ZERO, ONE, ONE, ONE};
                  n_in    = '0;
               end else begin
                  acc_in  = {ONE, ZERO, ZERO, ONE};
                  base_in = {ZERO, ONE, ONE, ONE};
                  n_in    = req_exponent - EXP_BITS'(1);
               end
            end
         end
         ST_RUN: begin
            case (ctrl.op)
               OP_JZ: begin
                  pc_in = (n_ff == '0) ? ctrl.target : pc_ff + PC_BITS'(1);
               end
               OP_JEVEN: begin
                  pc_in = !n_ff[0] ? ctrl.target : pc_ff + PC_BITS'(1);
               end
               OP_MUL: begin
                  sum_in = sum_next;
                  if (step_ff == STEP_DRAIN) begin
                     prod_in[ctrl.entry] = sum_next;
                     sum_in              = ZERO;
                     step_in             = '0;
                     pc_in               = pc_ff + PC_BITS'(1);
                  end else begin
                     mul_vld_in   = 1'b1;
                     mul_shift_in = (part != PART_LL);
                     mul_in       = PROD_BITS'(opa) * PROD_BITS'(opb);
                     step_in      = step_ff + STEP_BITS'(1);
                  end
               end
               OP_COPY_ACC: begin
                  acc_in = prod_ff;
                  pc_in  = pc_ff + PC_BITS'(1);
               end
               OP_COPY_BASE: begin
                  base_in = prod_ff;
                  n_in    = n_ff >> 1;
                  pc_in   = ctrl.target;
               end
               OP_DONE: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_in       = acc_ff;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= PC_TOP;
         step_ff      <= '0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         step_ff      <= step_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_shift_ff <= mul_shift_in;
         mul_ff       <= mul_in;
         sum_ff       <= sum_in;
         n_ff         <= n_in;
         acc_ff       <= acc_in;
         base_ff      <= base_in;
         prod_ff      <= prod_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_r00       = rsp_ff[0];
   assign rsp_r01       = rsp_ff[1];
   assign rsp_r10       = rsp_ff[2];
   assign rsp_r11       = rsp_ff[3];
   assign rsp_fib_value = rsp_ff[0];

endmodule
